FILE: rtl/core/cmfs_pkg.sv
`timescale 1ns / 1ps
// Package for the cube map face select unit: sizes, face codes and the item
// type that moves down the divider cell chain. No dependencies.
package cmfs_pkg;

  localparam int HALF_WIDTH    = 256;
  localparam int FRACTION_BITS = 8;

  localparam int DIR_W   = 16;
  localparam int COORD_W = 18;
  localparam int FACE_W  = 3;

  // HS: half width in fixed point
  localparam int HS      = HALF_WIDTH << FRACTION_BITS;
  // quotient width, quotient never exceeds HS
  localparam int Q_W     = $clog2(HS + 1);
  // component magnitude, up to 2^(DIR_W-1)
  localparam int MAG_W   = DIR_W;
  localparam int REM_W   = MAG_W;
  localparam int NUM_W   = MAG_W + Q_W;
  localparam int SUM_W   = Q_W + 1;
  localparam int WIDE_W  = (SUM_W > COORD_W) ? SUM_W : COORD_W;

  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int COORD_LIM = (2 * HS > COORD_MAX) ? COORD_MAX : 2 * HS;

  typedef enum logic [FACE_W-1:0] {
    FACE_POS_W = 3'd0,
    FACE_NEG_W = 3'd1,
    FACE_POS_U = 3'd2,
    FACE_NEG_U = 3'd3,
    FACE_POS_V = 3'd4,
    FACE_NEG_V = 3'd5
  } cmfs_face_e;

  typedef struct packed {
    cmfs_face_e       face;
    logic             zero;
    logic [MAG_W-1:0] m;
    logic             neg_s;
    logic             neg_t;
    logic [REM_W-1:0] rem_s;
    logic [REM_W-1:0] rem_t;
    logic [Q_W-1:0]   lo_s;
    logic [Q_W-1:0]   lo_t;
    logic [Q_W-1:0]   quo_s;
    logic [Q_W-1:0]   quo_t;
  } cmfs_div_t;

endpackage

FILE: rtl/core/cmfs_face_sel.sv
`timescale 1ns / 1ps
// Front stage: picks the face and major magnitude, selects the s/t numerators
// and loads the first divider remainder. Depends on cmfs_pkg.
module cmfs_face_sel import cmfs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [DIR_W-1:0] dir_x_i,
  input  logic signed [DIR_W-1:0] dir_y_i,
  input  logic signed [DIR_W-1:0] dir_z_i,
  output logic                    valid_o,
  output cmfs_div_t               item_o
);

  function automatic logic [MAG_W-1:0] mag(input logic signed [DIR_W:0] c);
    logic [DIR_W:0] t;
    t = c[DIR_W] ? -c : c;
    return t[MAG_W-1:0];
  endfunction

  logic signed [DIR_W:0] u, v, w;
  logic signed [DIR_W:0] a_s, a_t;
  logic [MAG_W-1:0]      m_u, m_v, m_w, m_max, mag_s, mag_t;
  cmfs_face_e            face;
  logic [NUM_W-1:0]      num_s, num_t;
  cmfs_div_t             item_d, item_q;
  logic                  valid_q;

  assign u = {dir_x_i[DIR_W-1], dir_x_i};
  assign v = -{dir_y_i[DIR_W-1], dir_y_i};
  assign w = -{dir_z_i[DIR_W-1], dir_z_i};
  assign m_u = mag(u);
  assign m_v = mag(v);
  assign m_w = mag(w);

  always_comb begin
    face  = FACE_POS_W;
    m_max = m_w;
    if (w[DIR_W]) begin
      face = FACE_NEG_W;
    end
    if (m_u > m_max) begin
      m_max = m_u;
      face  = u[DIR_W] ? FACE_NEG_U : FACE_POS_U;
    end
    if (m_v > m_max) begin
      m_max = m_v;
      face  = v[DIR_W] ? FACE_NEG_V : FACE_POS_V;
    end
    if (m_max == '0) begin
      face = FACE_POS_W;
    end
  end

  // s = HS + q(a_s), t = HS + q(a_t)
  always_comb begin
    case (face)
      FACE_POS_W: begin a_s = u;  a_t = -v; end
      FACE_NEG_W: begin a_s = -u; a_t = -v; end
      FACE_POS_U: begin a_s = -w; a_t = -v; end
      FACE_NEG_U: begin a_s = w;  a_t = -v; end
      FACE_POS_V: begin a_s = w;  a_t = -u; end
      default:    begin a_s = -u; a_t = w;  end
    endcase
  end

  assign mag_s = mag(a_s);
  assign mag_t = mag(a_t);
  assign num_s = NUM_W'(mag_s) * NUM_W'(HS);
  assign num_t = NUM_W'(mag_t) * NUM_W'(HS);

  always_comb begin
    item_d       = '0;
    item_d.face  = face;
    item_d.zero  = (m_max == '0);
    item_d.m     = m_max;
    item_d.neg_s = a_s[DIR_W];
    item_d.neg_t = a_t[DIR_W];
    item_d.rem_s = num_s[NUM_W-1:Q_W];
    item_d.rem_t = num_t[NUM_W-1:Q_W];
    item_d.lo_s  = num_s[Q_W-1:0];
    item_d.lo_t  = num_t[Q_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/core/cmfs_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division cell: produces one quotient bit for both the s and
// t lanes and hands the item to the next cell. Depends on cmfs_pkg.
module cmfs_div_cell import cmfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  cmfs_div_t item_i,
  output logic      valid_o,
  output cmfs_div_t item_o
);

  // returns {quotient bit, new remainder}
  function automatic logic [REM_W:0] step(input logic [REM_W-1:0] rem,
                                          input logic nbit,
                                          input logic [MAG_W-1:0] m);
    logic [REM_W:0] r2;
    logic [REM_W:0] diff;
    r2   = {rem, nbit};
    diff = r2 - {1'b0, m};
    if (r2 >= {1'b0, m}) begin
      return {1'b1, diff[REM_W-1:0]};
    end
    return {1'b0, r2[REM_W-1:0]};
  endfunction

  logic [REM_W:0] res_s, res_t;
  cmfs_div_t      item_d, item_q;
  logic           valid_q;

  assign res_s = step(item_i.rem_s, item_i.lo_s[Q_W-1], item_i.m);
  assign res_t = step(item_i.rem_t, item_i.lo_t[Q_W-1], item_i.m);

  always_comb begin
    item_d       = item_i;
    item_d.rem_s = res_s[REM_W-1:0];
    item_d.rem_t = res_t[REM_W-1:0];
    item_d.lo_s  = {item_i.lo_s[Q_W-2:0], 1'b0};
    item_d.lo_t  = {item_i.lo_t[Q_W-2:0], 1'b0};
    item_d.quo_s = {item_i.quo_s[Q_W-2:0], res_s[REM_W]};
    item_d.quo_t = {item_i.quo_t[Q_W-2:0], res_t[REM_W]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/core/cmfs_out_buf.sv
`timescale 1ns / 1ps
// Output stage: turns quotients into clamped coordinates and holds results in
// an output register with a skid entry. Depends on cmfs_pkg.
module cmfs_out_buf import cmfs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  cmfs_div_t          item_i,
  input  logic               stall_i,
  output logic               en_o,
  output logic               valid_o,
  output logic [FACE_W-1:0]  face_o,
  output logic [COORD_W-1:0] coord_s_o,
  output logic [COORD_W-1:0] coord_t_o
);

  typedef struct packed {
    logic [FACE_W-1:0]  face;
    logic [COORD_W-1:0] s;
    logic [COORD_W-1:0] t;
  } res_t;

  function automatic logic [COORD_W-1:0] to_coord(input logic [Q_W-1:0] q,
                                                  input logic neg);
    logic [SUM_W-1:0]  sum;
    logic [WIDE_W-1:0] wide;
    sum  = neg ? (SUM_W'(HS) - SUM_W'(q)) : (SUM_W'(HS) + SUM_W'(q));
    wide = WIDE_W'(sum);
    if (wide > WIDE_W'(COORD_MAX)) begin
      return COORD_W'(COORD_MAX);
    end
    return COORD_W'(wide);
  endfunction

  res_t res_d, out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic arr, take;

  always_comb begin
    res_d.face = item_i.face;
    res_d.s    = to_coord(item_i.zero ? '0 : item_i.quo_s, item_i.neg_s);
    res_d.t    = to_coord(item_i.zero ? '0 : item_i.quo_t, item_i.neg_t);
  end

  assign en_o = !skid_valid_q;
  assign arr  = valid_i && !skid_valid_q;
  assign take = out_valid_q && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (arr) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (arr) begin
      if (out_valid_q && !take) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign valid_o   = out_valid_q;
  assign face_o    = out_q.face;
  assign coord_s_o = out_q.s;
  assign coord_t_o = out_q.t;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a valid output");

  a_skid_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && stall_i))
    else $error("skid entry filled while output was free");

  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.s <= COORD_W'(COORD_LIM)) && (out_q.t <= COORD_W'(COORD_LIM)))
    else $error("coordinate beyond twice the half width");

  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.face <= FACE_NEG_V)
    else $error("face index out of range");

endmodule

FILE: rtl/core/cube_map_face_select_unit.sv
`timescale 1ns / 1ps
// Top level of the cube map face select unit: front stage, divider cell
// chain and output buffer. Depends on cmfs_pkg, cmfs_face_sel, cmfs_div_cell,
// cmfs_out_buf.
//
//   channel  | dir | valid        | stall        | payload
//   ---------+-----+--------------+--------------+-------------------------------
//   in       | in  | in_valid_i   | in_stall_o   | dir_x_i, dir_y_i, dir_z_i
//   out      | out | out_valid_o  | out_stall_i  | face_o, coord_s_o, coord_t_o
//
// One transaction per cycle while in_stall_o is low. Stages: one face
// select stage, one cell per quotient bit in the divider chain, one output stage.
// Reset clears all valid flags; no item is pending after reset.
// Downstream stall fills the skid entry, which then freezes the whole chain
// and raises in_stall_o until the held result is taken.
module cube_map_face_select_unit import cmfs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DIR_W-1:0] dir_x_i,
  input  logic signed [DIR_W-1:0] dir_y_i,
  input  logic signed [DIR_W-1:0] dir_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [FACE_W-1:0]       face_o,
  output logic [COORD_W-1:0]      coord_s_o,
  output logic [COORD_W-1:0]      coord_t_o
);

  logic      en;
  logic      chain_valid [Q_W+1];
  cmfs_div_t chain_item  [Q_W+1];

  assign in_stall_o = !en;

  cmfs_face_sel u_face_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .valid_o (chain_valid[0]),
    .item_o  (chain_item[0])
  );

  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    cmfs_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[i]),
      .item_i  (chain_item[i]),
      .valid_o (chain_valid[i+1]),
      .item_o  (chain_item[i+1])
    );
  end

  cmfs_out_buf u_out_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (chain_valid[Q_W]),
    .item_i    (chain_item[Q_W]),
    .stall_i   (out_stall_i),
    .en_o      (en),
    .valid_o   (out_valid_o),
    .face_o    (face_o),
    .coord_s_o (coord_s_o),
    .coord_t_o (coord_t_o)
  );

endmodule

FILE: tb/sv/cmfs_checker.sv
`timescale 1ns / 1ps
// Checker for the cube map face select unit: watches both channels, predicts
// face and texel coordinates per input transaction, compares in order.
// Depends on cmfs_pkg.
module cmfs_checker import cmfs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [DIR_W-1:0] dir_x_i,
  input  logic signed [DIR_W-1:0] dir_y_i,
  input  logic signed [DIR_W-1:0] dir_z_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [FACE_W-1:0]       face_i,
  input  logic [COORD_W-1:0]      coord_s_i,
  input  logic [COORD_W-1:0]      coord_t_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct {
    cmfs_face_e         face;
    logic [COORD_W-1:0] s;
    logic [COORD_W-1:0] t;
  } texel_t;

  texel_t expected_texels[$];
  int     fail_count = 0;
  int     pending    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  function automatic logic [COORD_W-1:0] clamp_coord(longint v);
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_W'(v);
  endfunction

  function automatic texel_t face_texel(logic signed [DIR_W-1:0] x,
                                        logic signed [DIR_W-1:0] y,
                                        logic signed [DIR_W-1:0] z);
    longint     u;
    longint     v;
    longint     w;
    longint     hs;
    longint     m;
    longint     qu;
    longint     qv;
    longint     qw;
    longint     s;
    longint     t;
    longint     cand[6];
    cmfs_face_e face;
    texel_t     res;
    u  = x;
    v  = -longint'(y);
    w  = -longint'(z);
    hs = HS;
    cand[0] = w;
    cand[1] = -w;
    cand[2] = u;
    cand[3] = -u;
    cand[4] = v;
    cand[5] = -v;
    m    = 0;
    face = FACE_POS_W;
    for (int i = 0; i < 6; i++) begin
      if (cand[i] > m) begin
        m    = cand[i];
        face = cmfs_face_e'(i);
      end
    end
    res.face = face;
    if (m == 0) begin
      res.s = clamp_coord(hs);
      res.t = clamp_coord(hs);
      return res;
    end
    qu = (hs * u) / m;
    qv = (hs * v) / m;
    qw = (hs * w) / m;
    case (face)
      FACE_POS_W: begin s = hs + qu; t = hs - qv; end
      FACE_NEG_W: begin s = hs - qu; t = hs - qv; end
      FACE_POS_U: begin s = hs - qw; t = hs - qv; end
      FACE_NEG_U: begin s = hs + qw; t = hs - qv; end
      FACE_POS_V: begin s = hs + qw; t = hs - qu; end
      default: begin s = hs - qu; t = hs + qw; end
    endcase
    res.s = clamp_coord(s);
    res.t = clamp_coord(t);
    return res;
  endfunction

  always @(posedge clk_i) begin
    texel_t exp_texel;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_texels.size() == 0) begin
          $error("unexpected result transaction: face %0d s %0d t %0d",
                 face_i, coord_s_i, coord_t_i);
          fail_count++;
        end else begin
          exp_texel = expected_texels.pop_front();
          if (face_i !== exp_texel.face) begin
            $error("face: expected %0d, got %0d", exp_texel.face, face_i);
            fail_count++;
          end
          if (coord_s_i !== exp_texel.s) begin
            $error("coord_s: expected %0d, got %0d", exp_texel.s, coord_s_i);
            fail_count++;
          end
          if (coord_t_i !== exp_texel.t) begin
            $error("coord_t: expected %0d, got %0d", exp_texel.t, coord_t_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_texels.push_back(face_texel(dir_x_i, dir_y_i, dir_z_i));
      end
      pending = expected_texels.size();
    end
  end

endmodule

FILE: tb/sv/cube_map_face_select_unit_tb.sv
`timescale 1ns / 1ps
// Top of the cube map face select unit testbench: clock, reset, directed and
// random direction stimulus, receiver stall and verdict.
// Depends on cmfs_pkg, cube_map_face_select_unit, cmfs_checker.
module cube_map_face_select_unit_tb import cmfs_pkg::*; ();

  localparam int RANDOM_PER_PHASE = 400;
  localparam int DRAIN_CYCLES     = 2 * (Q_W + 2) + 8;
  localparam int CYCLE_LIMIT      = 200000;

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  logic signed [DIR_W-1:0] dir_x       = '0;
  logic signed [DIR_W-1:0] dir_y       = '0;
  logic signed [DIR_W-1:0] dir_z       = '0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic [FACE_W-1:0]       face;
  logic [COORD_W-1:0]      coord_s;
  logic [COORD_W-1:0]      coord_t;
  int                      fail_count;
  int                      pending;
  int                      send_idle_pct  = 0;
  int                      recv_stall_pct = 0;
  int                      cycle_count    = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cube_map_face_select_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .dir_x_i     (dir_x),
    .dir_y_i     (dir_y),
    .dir_z_i     (dir_z),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .face_o      (face),
    .coord_s_o   (coord_s),
    .coord_t_o   (coord_t)
  );

  cmfs_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .dir_x_i      (dir_x),
    .dir_y_i      (dir_y),
    .dir_z_i      (dir_z),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .face_i       (face),
    .coord_s_i    (coord_s),
    .coord_t_i    (coord_t),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic send_dir(input logic signed [DIR_W-1:0] x,
                          input logic signed [DIR_W-1:0] y,
                          input logic signed [DIR_W-1:0] z);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    dir_x    <= x;
    dir_y    <= y;
    dir_z    <= z;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [DIR_W-1:0] pick_component();
    int sel;
    int r;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      r = $urandom_range(0, 32768);
      return DIR_W'(r - 16384);
    end
    if (sel < 80) return DIR_W'($urandom);
    case ($urandom_range(0, 7))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return -16'sd32768;
      4: return 16'sd32767;
      5: return 16'sd1;
      6: return -16'sd1;
      default: return DIR_W'($urandom_range(0, 15)) - 16'sd8;
    endcase
  endfunction

  // equal magnitudes with random signs hit the tie rules
  task automatic random_dir(output logic signed [DIR_W-1:0] x,
                            output logic signed [DIR_W-1:0] y,
                            output logic signed [DIR_W-1:0] z);
    logic signed [DIR_W-1:0] mag;
    x = pick_component();
    y = pick_component();
    z = pick_component();
    if ($urandom_range(0, 99) < 20) begin
      mag = DIR_W'($urandom_range(0, 16384));
      x = $urandom_range(0, 1) ? mag : -mag;
      y = $urandom_range(0, 1) ? mag : -mag;
      if ($urandom_range(0, 1)) z = $urandom_range(0, 1) ? mag : -mag;
    end
  endtask

  initial begin
    logic signed [DIR_W-1:0] rx;
    logic signed [DIR_W-1:0] ry;
    logic signed [DIR_W-1:0] rz;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_dir(16'sd0, 16'sd0, 16'sd0);
    send_dir(-16'sd32768, 16'sd0, 16'sd0);
    send_dir(16'sd0, 16'sd0, -16'sd16384);
    send_dir(16'sd0, 16'sd0, 16'sd16384);
    send_dir(16'sd16384, 16'sd0, 16'sd0);
    send_dir(-16'sd16384, 16'sd0, 16'sd0);
    send_dir(16'sd0, -16'sd16384, 16'sd0);
    send_dir(16'sd0, 16'sd16384, 16'sd0);
    send_dir(16'sd16384, 16'sd16384, 16'sd16384);
    send_dir(-16'sd16384, -16'sd16384, -16'sd16384);
    send_dir(-16'sd32768, -16'sd32768, -16'sd32768);
    send_dir(16'sd32767, 16'sd32767, 16'sd32767);
    send_dir(16'sd32767, -16'sd32768, 16'sd0);
    send_dir(16'sd1, 16'sd0, 16'sd0);
    send_dir(16'sd1, -16'sd1, 16'sd1);
    send_dir(-16'sd1, 16'sd1, -16'sd1);
    send_dir(16'sd16384, -16'sd16383, 16'sd12000);
    send_dir(-16'sd5000, 16'sd16384, -16'sd16384);
    send_dir(16'sd3, -16'sd16384, 16'sd16384);
    send_dir(-16'sd1, -16'sd32768, 16'sd32767);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 67; end
        default: begin send_idle_pct = 35; recv_stall_pct <= 35; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        random_dir(rx, ry, rz);
        send_dir(rx, ry, rz);
      end
    end
    in_valid       <= 1'b0;
    recv_stall_pct <= 0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: cube_map_face_select_unit.f
rtl/core/cmfs_pkg.sv
rtl/core/cmfs_face_sel.sv
rtl/core/cmfs_div_cell.sv
rtl/core/cmfs_out_buf.sv
rtl/core/cube_map_face_select_unit.sv
tb/sv/cmfs_checker.sv
tb/sv/cube_map_face_select_unit_tb.sv
